FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the clock calendar checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define CCD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("clock calendar check failed");

// The condition must never be seen outside reset.
`define CCD_ASSERT_NEVER(lbl, clk, rstn, cond) \
    `CCD_ASSERT(lbl, clk, rstn, !(cond))

`endif

FILE: hw/rtl/ccd_pkg.sv
// ----------------------------------------------------------------------------
// Clock calendar package
// Types, command codes and constants shared by the clock calendar modules.
// ----------------------------------------------------------------------------
package ccd_pkg;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_SET_TIME  = 3'd1,
        CMD_SET_DATE  = 3'd2,
        CMD_ADD_TIME  = 3'd3,
        CMD_SHOW_TIME = 3'd4,
        CMD_SHOW_DATE = 3'd5,
        CMD_SHOW_TERM = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
    } cal_t;

    typedef struct packed {
        cmd_t command;
        logic display_mode;
        cal_t value;
    } item_t;

    localparam int NUM_DIGITS = 8;
    localparam int POS_W      = 3;
    localparam int CODE_W     = 5;

    localparam logic [4:0] RST_HOUR   = 5'd12;
    localparam logic [5:0] RST_MINUTE = 6'd0;
    localparam logic [5:0] RST_SECOND = 6'd0;
    localparam logic [7:0] RST_YEAR   = 8'd21;
    localparam logic [3:0] RST_MONTH  = 4'd6;
    localparam logic [4:0] RST_DAY    = 5'd20;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [5:0] SECOND_MAX = 6'd59;
    localparam logic [3:0] MONTH_MAX  = 4'd12;

    localparam logic [CODE_W-1:0] CODE_DASH    = 5'd16;
    localparam logic [CODE_W-1:0] CODE_BLANK   = 5'd17;
    localparam logic [CODE_W-1:0] CODE_NOMATCH = 5'd19;
    localparam logic [CODE_W-1:0] CODE_FILL    = 5'd20;

endpackage

FILE: hw/rtl/clock_calendar_with_display.sv
// ----------------------------------------------------------------------------
// Clock calendar with display
// Real-time clock and calendar driven by command words, with a display encoder.
// ----------------------------------------------------------------------------
// Each input word is one command: tick, set time, set date, add time, or one of
// three show commands. Tick, set, add and the unused code give one result word
// each, so such words may follow each other in every cycle while the output is
// not stalled. Show commands give eight result words, one display position a
// cycle from the output register while the output is not stalled. The input
// register takes the next command while the last result of the current one is
// being handed out, and a result is held in the output register after its command.
module clock_calendar_with_display (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // hour_value, minute_value, second_value, year_value, month_value, day_value
    input  logic [39:0] s_axis_tdata,
    // command, display_mode
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cur_hour, cur_minute, cur_second, cur_year, cur_month, cur_day,
    // alarm_check, digit_position, digit_code
    output logic [47:0] m_axis_tdata,
    // digit_valid
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import ccd_pkg::*;

    item_t            item_in;
    item_t            item_reg;
    logic             item_valid_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    cal_t              cal_next;
    logic              alarm;
    logic [CODE_W-1:0] disp_code;

    logic             m_valid_reg;
    cal_t             out_cal_reg;
    logic             out_alarm_reg;
    logic             out_dvalid_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic             out_last_reg;

    logic is_show;
    logic out_load;
    logic item_last;
    logic item_done;

    always_comb begin
        item_in.command      = cmd_t'(s_axis_tuser[2:0]);
        item_in.display_mode = s_axis_tuser[3];
        item_in.value.hour   = s_axis_tdata[4:0];
        item_in.value.minute = s_axis_tdata[10:5];
        item_in.value.second = s_axis_tdata[16:11];
        item_in.value.year   = s_axis_tdata[24:17];
        item_in.value.month  = s_axis_tdata[28:25];
        item_in.value.day    = s_axis_tdata[33:29];
    end

    assign is_show = (item_reg.command == CMD_SHOW_TIME) ||
                     (item_reg.command == CMD_SHOW_DATE) ||
                     (item_reg.command == CMD_SHOW_TERM);
    assign out_load  = item_valid_reg && (!m_valid_reg || m_axis_tready);
    assign item_last = !is_show || (pos_reg == POS_W'(NUM_DIGITS - 1));
    assign item_done = out_load && item_last;
    assign s_axis_tready = !item_valid_reg || item_done;
    assign pos_next = item_done ? '0 : (out_load ? pos_reg + 1'b1 : pos_reg);

    ccd_time u_time (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update_en (item_done),
        .item      (item_reg),
        .cal_next  (cal_next),
        .alarm     (alarm)
    );

    ccd_disp u_disp (
        .cal          (cal_next),
        .command      (item_reg.command),
        .display_mode (item_reg.display_mode),
        .position     (pos_reg),
        .code         (disp_code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            pos_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                item_valid_reg <= s_axis_tvalid;
            end
            pos_reg <= pos_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            item_reg <= item_in;
        end
        if (out_load) begin
            out_cal_reg    <= cal_next;
            out_alarm_reg  <= alarm;
            out_dvalid_reg <= is_show;
            out_pos_reg    <= is_show ? pos_reg : '0;
            out_code_reg   <= is_show ? disp_code : '0;
            out_last_reg   <= item_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, out_code_reg, out_pos_reg, out_alarm_reg,
                            out_cal_reg.day, out_cal_reg.month, out_cal_reg.year,
                            out_cal_reg.second, out_cal_reg.minute, out_cal_reg.hour};
    assign m_axis_tuser  = out_dvalid_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/ccd_time.sv
// ----------------------------------------------------------------------------
// Clock calendar time keeper
// Holds the time of day and the date and works out their next values.
// ----------------------------------------------------------------------------
module ccd_time (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          update_en,
    input  ccd_pkg::item_t item,
    output ccd_pkg::cal_t  cal_next,
    output logic          alarm
);
    import ccd_pkg::*;

    cal_t cal_reg;

    function automatic logic [5:0] month_len(input logic [3:0] m, input logic [7:0] y);
        logic [5:0] len;
        case (m)
            4'd2: begin
                len = (y[1:0] == 2'b00) ? 6'd29 : 6'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 6'd30;
            end
            default: begin
                len = 6'd31;
            end
        endcase
        return len;
    endfunction

    logic [5:0] len;
    logic [5:0] day_inc;
    logic [6:0] sec_sum;
    logic [6:0] min_sum;
    logic [5:0] hour_sum;
    logic [1:0] sec_carry;
    logic [1:0] min_carry;

    always_comb begin
        cal_next  = cal_reg;
        alarm     = 1'b0;
        len       = month_len(cal_reg.month, cal_reg.year);
        day_inc   = {1'b0, cal_reg.day} + 6'd1;
        sec_sum   = {1'b0, cal_reg.second} + {1'b0, item.value.second};
        sec_carry = 2'd0;
        min_sum   = 7'd0;
        min_carry = 2'd0;
        hour_sum  = 6'd0;
        case (item.command)
            CMD_TICK: begin
                if (cal_reg.second >= SECOND_MAX) begin
                    cal_next.second = 6'd0;
                    alarm = 1'b1;
                    if (cal_reg.minute >= MINUTE_MAX) begin
                        cal_next.minute = 6'd0;
                        if (cal_reg.hour >= HOUR_MAX) begin
                            cal_next.hour = 5'd0;
                            if (day_inc > len) begin
                                cal_next.day = 5'(day_inc - len);
                                if (cal_reg.month >= MONTH_MAX) begin
                                    cal_next.month = 4'd1;
                                    cal_next.year  = cal_reg.year + 8'd1;
                                end else begin
                                    cal_next.month = cal_reg.month + 4'd1;
                                end
                            end else begin
                                cal_next.day = day_inc[4:0];
                            end
                        end else begin
                            cal_next.hour = cal_reg.hour + 5'd1;
                        end
                    end else begin
                        cal_next.minute = cal_reg.minute + 6'd1;
                    end
                end else begin
                    cal_next.second = cal_reg.second + 6'd1;
                end
            end
            CMD_SET_TIME: begin
                cal_next.hour   = (item.value.hour > HOUR_MAX) ? HOUR_MAX : item.value.hour;
                cal_next.minute = (item.value.minute > MINUTE_MAX) ?
                                  MINUTE_MAX : item.value.minute;
                cal_next.second = (item.value.second > SECOND_MAX) ?
                                  SECOND_MAX : item.value.second;
            end
            CMD_SET_DATE: begin
                cal_next.year = item.value.year;
                if (item.value.month == 4'd0) begin
                    cal_next.month = 4'd1;
                end else if (item.value.month > MONTH_MAX) begin
                    cal_next.month = MONTH_MAX;
                end else begin
                    cal_next.month = item.value.month;
                end
                cal_next.day = (item.value.day == 5'd0) ? 5'd1 : item.value.day;
            end
            CMD_ADD_TIME: begin
                if (sec_sum >= 7'd120) begin
                    cal_next.second = 6'(sec_sum - 7'd120);
                    sec_carry = 2'd2;
                end else if (sec_sum >= 7'd60) begin
                    cal_next.second = 6'(sec_sum - 7'd60);
                    sec_carry = 2'd1;
                end else begin
                    cal_next.second = sec_sum[5:0];
                end
                min_sum = {1'b0, cal_reg.minute} + {1'b0, item.value.minute}
                        + {5'd0, sec_carry};
                if (min_sum >= 7'd120) begin
                    cal_next.minute = 6'(min_sum - 7'd120);
                    min_carry = 2'd2;
                end else if (min_sum >= 7'd60) begin
                    cal_next.minute = 6'(min_sum - 7'd60);
                    min_carry = 2'd1;
                end else begin
                    cal_next.minute = min_sum[5:0];
                end
                hour_sum = {1'b0, cal_reg.hour} + {1'b0, item.value.hour}
                         + {4'd0, min_carry};
                if (hour_sum >= 6'd48) begin
                    cal_next.hour = 5'(hour_sum - 6'd48);
                end else if (hour_sum >= 6'd24) begin
                    cal_next.hour = 5'(hour_sum - 6'd24);
                end else begin
                    cal_next.hour = hour_sum[4:0];
                end
            end
            default: begin
                cal_next = cal_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg.hour   <= RST_HOUR;
            cal_reg.minute <= RST_MINUTE;
            cal_reg.second <= RST_SECOND;
            cal_reg.year   <= RST_YEAR;
            cal_reg.month  <= RST_MONTH;
            cal_reg.day    <= RST_DAY;
        end else if (update_en) begin
            cal_reg <= cal_next;
        end
    end

endmodule

FILE: hw/rtl/ccd_disp.sv
// ----------------------------------------------------------------------------
// Clock calendar display encoder
// Gives the glyph code of one display position for the three show commands.
// ----------------------------------------------------------------------------
module ccd_disp (
    input  ccd_pkg::cal_t  cal,
    input  ccd_pkg::cmd_t  command,
    input  logic           display_mode,
    input  logic [2:0]     position,
    output logic [4:0]     code
);
    import ccd_pkg::*;

    localparam int NUM_TERMS = 24;

    localparam logic [3:0] TERM_MONTH [NUM_TERMS] = '{
        4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7,
        4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd1, 4'd1
    };
    localparam logic [4:0] TERM_DAY [NUM_TERMS] = '{
        5'd3, 5'd18, 5'd5, 5'd20, 5'd4, 5'd20, 5'd5, 5'd21, 5'd5, 5'd21, 5'd7, 5'd22,
        5'd7, 5'd23, 5'd7, 5'd23, 5'd8, 5'd23, 5'd7, 5'd22, 5'd7, 5'd21, 5'd5, 5'd20
    };
    localparam logic [4:0] SEASON_HEAD [4] = '{5'd5, 5'd5, 5'd10, 5'd8};
    localparam logic [4:0] SEASON_TAIL [4] = '{5'd17, 5'd18, 5'd18, 5'd1};

    function automatic logic [4:0] div10(input logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * 16'd205;
        return p[15:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [7:0] v);
        logic [7:0] r;
        r = v - 8'(div10(v)) * 8'd10;
        return r[3:0];
    endfunction

    function automatic logic [1:0] div100(input logic [7:0] v);
        logic [13:0] p;
        p = 14'(v) * 14'd41;
        return p[13:12];
    endfunction

    logic [4:0] codes [NUM_DIGITS];
    logic [4:0] year_tens;

    always_comb begin
        year_tens = div10(cal.year);
        for (int k = 0; k < NUM_DIGITS; k++) begin
            codes[k] = 5'd0;
        end
        case (command)
            CMD_SHOW_TIME: begin
                if (!display_mode) begin
                    codes[0] = div10({2'b0, cal.minute});
                    codes[1] = {1'b0, mod10({2'b0, cal.minute})};
                    codes[2] = CODE_DASH;
                    codes[3] = div10({2'b0, cal.second});
                    codes[4] = {1'b0, mod10({2'b0, cal.second})};
                    codes[5] = CODE_BLANK;
                    codes[6] = CODE_BLANK;
                    codes[7] = CODE_BLANK;
                end else begin
                    codes[0] = div10({3'b0, cal.hour});
                    codes[1] = {1'b0, mod10({3'b0, cal.hour})};
                    codes[2] = CODE_DASH;
                    codes[3] = div10({2'b0, cal.minute});
                    codes[4] = {1'b0, mod10({2'b0, cal.minute})};
                    codes[5] = CODE_DASH;
                    codes[6] = div10({2'b0, cal.second});
                    codes[7] = {1'b0, mod10({2'b0, cal.second})};
                end
            end
            CMD_SHOW_DATE: begin
                codes[0] = 5'd2;
                codes[1] = {3'b0, div100(cal.year)};
                codes[2] = {1'b0, mod10({3'b0, year_tens})};
                codes[3] = {1'b0, mod10(cal.year)};
                codes[4] = div10({4'b0, cal.month});
                codes[5] = {1'b0, mod10({4'b0, cal.month})};
                codes[6] = div10({3'b0, cal.day});
                codes[7] = {1'b0, mod10({3'b0, cal.day})};
            end
            CMD_SHOW_TERM: begin
                for (int k = 0; k < 5; k++) begin
                    codes[k] = CODE_FILL;
                end
                codes[5] = CODE_NOMATCH;
                codes[6] = CODE_NOMATCH;
                codes[7] = CODE_NOMATCH;
                for (int i = NUM_TERMS - 1; i >= 0; i--) begin
                    if (TERM_MONTH[i] == cal.month && TERM_DAY[i] == cal.day) begin
                        codes[5] = SEASON_HEAD[i / 6];
                        codes[6] = SEASON_TAIL[i / 6];
                        codes[7] = 5'(i % 6 + 1);
                    end
                end
            end
            default: begin
                codes[0] = 5'd0;
            end
        endcase
        code = codes[position];
    end

endmodule

FILE: hw/rtl/ccd_checker.sv
// ----------------------------------------------------------------------------
// Clock calendar port checker
// Watches the result words of the clock calendar and is bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [3:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    `CCD_ASSERT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `CCD_ASSERT(a_plain_word, aclk, aresetn, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[42:35] == 8'd0)
    `CCD_ASSERT(a_show_end, aclk, aresetn, m_axis_tvalid && m_axis_tuser && m_axis_tlast |-> m_axis_tdata[37:35] == 3'd7)
    `CCD_ASSERT(a_show_mid, aclk, aresetn, m_axis_tvalid && m_axis_tuser && !m_axis_tlast |-> m_axis_tdata[37:35] != 3'd7)
    `CCD_ASSERT_NEVER(a_range, aclk, aresetn, m_axis_tvalid && (m_axis_tdata[4:0] > 5'd23 || m_axis_tdata[10:5] > 6'd59 || m_axis_tdata[16:11] > 6'd59))

endmodule

bind clock_calendar_with_display ccd_checker u_ccd_checker (.*);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Clock calendar with display: stream testbench
// Drives command words into the clock calendar and checks every result word
// against a cycle-free model of the time, date and display logic. A directed
// table covers reset values, clamping, rollovers and every command. Random
// sequences then follow under three idling regimes, the last with a long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ccd_pkg::*;

    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 40;

    typedef struct {
        logic [2:0] cmd;
        logic       mode;
        cal_t       v;
    } cmd_word_t;

    typedef struct {
        cal_t       cal;
        logic       alarm;
        logic       dvalid;
        logic [2:0] pos;
        logic [4:0] code;
        logic       last;
    } disp_word_t;

    typedef struct {
        cmd_word_t w;
        bit        chk;
        cal_t      ecal;
        logic      ealarm;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // hour_value, minute_value, second_value, year_value, month_value, day_value
    logic [39:0] s_axis_tdata;
    // command, display_mode
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // cur_hour, cur_minute, cur_second, cur_year, cur_month, cur_day,
    // alarm_check, digit_position, digit_code
    logic [47:0] m_axis_tdata;
    // digit_valid
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int errors;

    cal_t        clock_now;
    disp_word_t  pending_words[$];
    stim_row_t   stim_table[$];

    int term_month[24] = '{2, 2, 3, 3, 4, 4, 5, 5, 6, 6, 7, 7,
                           8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 1, 1};
    int term_day[24]   = '{3, 18, 5, 20, 4, 20, 5, 21, 5, 21, 7, 22,
                           7, 23, 7, 23, 8, 23, 7, 22, 7, 21, 5, 20};
    int season_a[4]    = '{5, 5, 10, 8};
    int season_b[4]    = '{17, 18, 18, 1};

    clock_calendar_with_display dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic cal_t mk_cal(input int h, input int m, input int s,
                                    input int y, input int mo, input int d);
        cal_t c;
        c.hour   = 5'(h);
        c.minute = 6'(m);
        c.second = 6'(s);
        c.year   = 8'(y);
        c.month  = 4'(mo);
        c.day    = 5'(d);
        return c;
    endfunction

    function automatic cmd_word_t mk_word(input logic [2:0] cmd, input logic mode,
                                          input cal_t v);
        cmd_word_t w;
        w.cmd  = cmd;
        w.mode = mode;
        w.v    = v;
        return w;
    endfunction

    function automatic int month_days(input int mo, input int yr);
        case (mo)
            2: return (yr % 4 == 0) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic string word_str(input disp_word_t w);
        return $sformatf("h%0d m%0d s%0d y%0d mo%0d d%0d al%0b dv%0b pos%0d code%0d last%0b",
                         w.cal.hour, w.cal.minute, w.cal.second, w.cal.year, w.cal.month,
                         w.cal.day, w.alarm, w.dvalid, w.pos, w.code, w.last);
    endfunction

    // Applies one command to the calendar copy and queues the words it causes.
    task automatic predict_words(input cmd_word_t w, output int n);
        int h, m, s, y, mo, d, len, term, sum_s, sum_m;
        int code[8];
        logic alarm;
        disp_word_t e;
        h = clock_now.hour;
        m = clock_now.minute;
        s = clock_now.second;
        y = clock_now.year;
        mo = clock_now.month;
        d = clock_now.day;
        alarm = 1'b0;
        n = 1;
        term = -1;
        case (w.cmd)
            CMD_TICK: begin
                s++;
                if (s > 59) begin
                    s = 0;
                    alarm = 1'b1;
                    m++;
                    if (m > 59) begin
                        m = 0;
                        h++;
                        if (h > 23) begin
                            h = 0;
                            len = month_days(mo, y);
                            d++;
                            if (d > len) begin
                                d -= len;
                                mo++;
                                if (mo > 12) begin
                                    mo -= 12;
                                    y = (y + 1) % 256;
                                end
                            end
                        end
                    end
                end
            end
            CMD_SET_TIME: begin
                h = (w.v.hour > 23) ? 23 : w.v.hour;
                m = (w.v.minute > 59) ? 59 : w.v.minute;
                s = (w.v.second > 59) ? 59 : w.v.second;
            end
            CMD_SET_DATE: begin
                y = w.v.year;
                mo = (w.v.month == 0) ? 1 : ((w.v.month > 12) ? 12 : w.v.month);
                d = (w.v.day == 0) ? 1 : w.v.day;
            end
            CMD_ADD_TIME: begin
                sum_s = s + w.v.second;
                sum_m = m + w.v.minute + sum_s / 60;
                h = (h + w.v.hour + sum_m / 60) % 24;
                m = sum_m % 60;
                s = sum_s % 60;
            end
            CMD_SHOW_TIME: begin
                n = 8;
                if (w.mode == 1'b0) begin
                    code = '{m / 10, m % 10, 16, s / 10, s % 10, 17, 17, 17};
                end else begin
                    code = '{h / 10, h % 10, 16, m / 10, m % 10, 16, s / 10, s % 10};
                end
            end
            CMD_SHOW_DATE: begin
                n = 8;
                code = '{2, y / 100, (y / 10) % 10, y % 10, mo / 10, mo % 10, d / 10, d % 10};
            end
            CMD_SHOW_TERM: begin
                n = 8;
                for (int i = 0; i < 24; i++) begin
                    if (term < 0 && term_month[i] == mo && term_day[i] == d) term = i;
                end
                if (term < 0) begin
                    code = '{20, 20, 20, 20, 20, 19, 19, 19};
                end else begin
                    code = '{20, 20, 20, 20, 20, season_a[term / 6], season_b[term / 6],
                             term % 6 + 1};
                end
            end
            default: ;
        endcase
        clock_now = mk_cal(h, m, s, y, mo, d);
        for (int k = 0; k < n; k++) begin
            e.cal    = clock_now;
            e.alarm  = alarm;
            e.dvalid = (n == 8);
            e.pos    = (n == 8) ? 3'(k) : 3'd0;
            e.code   = (n == 8) ? 5'(code[k]) : 5'd0;
            e.last   = (k == n - 1);
            pending_words.push_back(e);
        end
    endtask

    // Entered and left at a falling edge.
    task automatic send_item(input cmd_word_t w, input bit chk, input cal_t ecal,
                             input logic ealarm);
        int n;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, w.v.day, w.v.month, w.v.year, w.v.second, w.v.minute,
                          w.v.hour};
        s_axis_tuser  <= {w.mode, w.cmd};
        do @(posedge aclk); while (!s_axis_tready);
        predict_words(w, n);
        if (chk) begin
            for (int k = pending_words.size() - n; k < pending_words.size(); k++) begin
                pending_words[k].cal   = ecal;
                pending_words[k].alarm = ealarm;
            end
        end
        @(negedge aclk);
    endtask

    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        bit wide;
        wide   = ($urandom_range(7) == 0);
        w.cmd  = ($urandom_range(15) == 15) ? CMD_UNUSED : 3'($urandom_range(6));
        w.mode = 1'($urandom_range(1));
        w.v.hour   = 5'(wide ? $urandom_range(31) : $urandom_range(23));
        w.v.minute = 6'(wide ? $urandom_range(63) : $urandom_range(59));
        w.v.second = 6'(wide ? $urandom_range(63) : $urandom_range(59));
        w.v.year   = 8'($urandom_range(255));
        w.v.month  = 4'(wide ? $urandom_range(15) : $urandom_range(1, 12));
        w.v.day    = 5'(wide ? $urandom_range(31) : $urandom_range(1, 31));
        return w;
    endfunction

    // Mostly date and time set close to a rollover, a term show, a few ticks and a
    // further show; the rest are loose random words.
    task automatic run_random(input int count);
        int sent, ticks, pick;
        cmd_word_t w;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) < 4) begin
                pick = $urandom_range(23);
                w = rand_word();
                w.cmd = CMD_SET_DATE;
                if ($urandom_range(1) == 1) begin
                    w.v.month = 4'(term_month[pick]);
                    w.v.day   = 5'(term_day[pick]);
                end else begin
                    w.v.month = 4'($urandom_range(1, 12));
                    w.v.day   = 5'($urandom_range(27, 31));
                end
                send_item(w, 1'b0, '0, 1'b0);
                w = rand_word();
                w.cmd = CMD_SET_TIME;
                w.v.hour   = 5'd23;
                w.v.minute = ($urandom_range(3) == 0) ? 6'($urandom_range(59)) : 6'd59;
                w.v.second = 6'($urandom_range(56, 59));
                send_item(w, 1'b0, '0, 1'b0);
                w.cmd = CMD_SHOW_TERM;
                send_item(w, 1'b0, '0, 1'b0);
                ticks = $urandom_range(1, 4);
                repeat (ticks) begin
                    w = rand_word();
                    w.cmd = CMD_TICK;
                    send_item(w, 1'b0, '0, 1'b0);
                end
                w = rand_word();
                w.cmd = ($urandom_range(1) == 1) ? CMD_SHOW_DATE : CMD_SHOW_TERM;
                send_item(w, 1'b0, '0, 1'b0);
                sent += ticks + 4;
            end else begin
                send_item(rand_word(), 1'b0, '0, 1'b0);
                sent++;
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic add_row(input cmd_word_t w, input bit chk, input cal_t ecal,
                           input logic ealarm);
        stim_row_t r;
        r.w = w;
        r.chk = chk;
        r.ecal = ecal;
        r.ealarm = ealarm;
        stim_table.push_back(r);
    endtask

    task automatic build_table();
        add_row(mk_word(CMD_SHOW_DATE, 1'b0, '0), 1'b1,
                mk_cal(RST_HOUR, RST_MINUTE, RST_SECOND, RST_YEAR, RST_MONTH, RST_DAY), 1'b0);
        add_row(mk_word(CMD_SHOW_TIME, 1'b1, '0), 1'b1,
                mk_cal(RST_HOUR, RST_MINUTE, RST_SECOND, RST_YEAR, RST_MONTH, RST_DAY), 1'b0);
        add_row(mk_word(CMD_SET_TIME, 1'b1, mk_cal(31, 63, 63, 255, 15, 31)), 1'b1,
                mk_cal(23, 59, 59, 21, 6, 20), 1'b0);
        add_row(mk_word(CMD_TICK, 1'b0, '0), 1'b1, mk_cal(0, 0, 0, 21, 6, 21), 1'b1);
        add_row(mk_word(CMD_TICK, 1'b1, mk_cal(31, 63, 63, 255, 15, 31)), 1'b1,
                mk_cal(0, 0, 1, 21, 6, 21), 1'b0);
        add_row(mk_word(CMD_SET_DATE, 1'b0, mk_cal(31, 63, 63, 255, 12, 31)), 1'b1,
                mk_cal(0, 0, 1, 255, 12, 31), 1'b0);
        add_row(mk_word(CMD_SET_TIME, 1'b0, mk_cal(23, 59, 59, 0, 0, 0)), 1'b1,
                mk_cal(23, 59, 59, 255, 12, 31), 1'b0);
        add_row(mk_word(CMD_TICK, 1'b0, '0), 1'b1, mk_cal(0, 0, 0, 0, 1, 1), 1'b1);
        add_row(mk_word(CMD_SET_DATE, 1'b0, mk_cal(0, 0, 0, 0, 0, 0)), 1'b1,
                mk_cal(0, 0, 0, 0, 1, 1), 1'b0);
        add_row(mk_word(CMD_SET_DATE, 1'b1, mk_cal(0, 0, 0, 4, 15, 0)), 1'b1,
                mk_cal(0, 0, 0, 4, 12, 1), 1'b0);
        add_row(mk_word(CMD_SET_DATE, 1'b0, mk_cal(0, 0, 0, 4, 2, 29)), 1'b1,
                mk_cal(0, 0, 0, 4, 2, 29), 1'b0);
        add_row(mk_word(CMD_SHOW_TERM, 1'b0, '0), 1'b0, '0, 1'b0);
        add_row(mk_word(CMD_SET_TIME, 1'b0, mk_cal(23, 59, 59, 0, 0, 0)), 1'b1,
                mk_cal(23, 59, 59, 4, 2, 29), 1'b0);
        add_row(mk_word(CMD_TICK, 1'b0, '0), 1'b1, mk_cal(0, 0, 0, 4, 3, 1), 1'b1);
        add_row(mk_word(CMD_SET_DATE, 1'b0, mk_cal(0, 0, 0, 5, 4, 31)), 1'b1,
                mk_cal(0, 0, 0, 5, 4, 31), 1'b0);
        add_row(mk_word(CMD_SET_TIME, 1'b0, mk_cal(23, 59, 59, 0, 0, 0)), 1'b1,
                mk_cal(23, 59, 59, 5, 4, 31), 1'b0);
        add_row(mk_word(CMD_TICK, 1'b0, '0), 1'b1, mk_cal(0, 0, 0, 5, 5, 2), 1'b1);
        add_row(mk_word(CMD_ADD_TIME, 1'b0, mk_cal(31, 63, 63, 0, 0, 0)), 1'b1,
                mk_cal(8, 4, 3, 5, 5, 2), 1'b0);
        add_row(mk_word(CMD_SHOW_TIME, 1'b0, '0), 1'b0, '0, 1'b0);
        add_row(mk_word(CMD_SET_DATE, 1'b0, mk_cal(0, 0, 0, 100, 3, 20)), 1'b1,
                mk_cal(8, 4, 3, 100, 3, 20), 1'b0);
        add_row(mk_word(CMD_SHOW_TERM, 1'b1, '0), 1'b0, '0, 1'b0);
        add_row(mk_word(CMD_SHOW_DATE, 1'b0, '0), 1'b0, '0, 1'b0);
        add_row(mk_word(CMD_UNUSED, 1'b1, mk_cal(31, 63, 63, 255, 15, 31)), 1'b1,
                mk_cal(8, 4, 3, 100, 3, 20), 1'b0);
        add_row(mk_word(CMD_SET_DATE, 1'b0, mk_cal(0, 0, 0, 21, 1, 20)), 1'b1,
                mk_cal(8, 4, 3, 21, 1, 20), 1'b0);
        add_row(mk_word(CMD_SHOW_TERM, 1'b0, '0), 1'b0, '0, 1'b0);
    endtask

    // Receiver: random back-pressure, or a counted hold-off when one is asked for.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        disp_word_t got;
        disp_word_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.cal.hour   = m_axis_tdata[4:0];
            got.cal.minute = m_axis_tdata[10:5];
            got.cal.second = m_axis_tdata[16:11];
            got.cal.year   = m_axis_tdata[24:17];
            got.cal.month  = m_axis_tdata[28:25];
            got.cal.day    = m_axis_tdata[33:29];
            got.alarm      = m_axis_tdata[34];
            got.pos        = m_axis_tdata[37:35];
            got.code       = m_axis_tdata[42:38];
            got.dvalid     = m_axis_tuser;
            got.last       = m_axis_tlast;
            if (pending_words.size() == 0) begin
                if (errors < 10) $display("%0t: unexpected word %s", $realtime, word_str(got));
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (got.cal.hour !== want.cal.hour || got.cal.minute !== want.cal.minute ||
                    got.cal.second !== want.cal.second || got.cal.year !== want.cal.year ||
                    got.cal.month !== want.cal.month || got.cal.day !== want.cal.day ||
                    got.alarm !== want.alarm || got.dvalid !== want.dvalid ||
                    got.pos !== want.pos || got.code !== want.code ||
                    got.last !== want.last) begin
                    if (errors < 10) begin
                        $display("%0t: mismatch", $realtime);
                        $display("  expected %s", word_str(want));
                        $display("  actual   %s", word_str(got));
                    end
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_left     = 0;
        errors        = 0;
        send_idle_pct = 30;
        recv_idle_pct = 68;
        clock_now = mk_cal(RST_HOUR, RST_MINUTE, RST_SECOND, RST_YEAR, RST_MONTH, RST_DAY);
        build_table();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_table[i])
            send_item(stim_table[i].w, stim_table[i].chk, stim_table[i].ecal,
                      stim_table[i].ealarm);
        run_random(25);
        drain_results();

        send_idle_pct = 68;
        recv_idle_pct = 30;
        run_random(25);
        drain_results();

        // No idling; the receiver holds off for a long stretch at the start.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        @(negedge aclk);
        run_random(25);
        drain_results();

        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
